### rtl/fsf_pkg.sv
// ----------------------------------------------------------------------------
// FIR stream filter package
// Shared constants and command codes for the streaming FIR filter.
// ----------------------------------------------------------------------------
package fsf_pkg;

	// Default build values.
	localparam int MAX_TAPS_DEF    = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths.
	localparam int COEF_BITS    = 16;
	localparam int COEF_FRAC    = 15;
	localparam int TAPS_BITS    = 6;
	localparam int TAP_IDX_BITS = 5;

	// Tap count after reset, before clamping to the build size.
	localparam int TAPS_RESET = 32;

	// Request commands.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_COEF   = 1'b1;

endpackage

### rtl/fsf_if.sv
// ----------------------------------------------------------------------------
// FIR stream filter channels
// Valid/ready channels for incoming requests and outgoing filter results.
// ----------------------------------------------------------------------------
interface fsf_item_if import fsf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic [TAP_IDX_BITS-1:0]        tap_index;
	logic signed [COEF_BITS-1:0]    coeff_value;
	logic signed [SAMPLE_BITS-1:0]  sample;

	modport source (output valid, command, tap_index, coeff_value, sample, input ready);
	modport sink   (input valid, command, tap_index, coeff_value, sample, output ready);
endinterface

interface fsf_result_if import fsf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_BITS-1:0]  filtered;

	modport source (output valid, filtered, input ready);
	modport sink   (input valid, filtered, output ready);
endinterface

### rtl/fir_filter_stream_top.sv
// ----------------------------------------------------------------------------
// FIR stream filter top level
// Direct-form FIR filter with a sample ring and a coefficient memory, one
// multiply-accumulate per tap.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake        Carries
//   item       in         valid / ready    command, tap_index, coeff_value, sample
//   result     out        valid / ready    filtered
//   cfg        in         cfg_we only      cfg_wdata = taps_in_use
//
// A coefficient request is written at acceptance and leaves the engine idle. A
// sample request runs the single multiply-accumulate loop, which reads one tap
// per cycle from the two memories, then drains, finishes and loads the result;
// with zero taps in use it goes straight to the finish step.
// Reset clears the control state at once; no clearing pass runs. Sample
// history is masked by a fill count and coefficients by per-entry valid bits.
// A new request is taken while a finished result waits on the output; the
// engine only holds in its last step if the output register is still full.
// ----------------------------------------------------------------------------
module fir_filter_stream_top import fsf_pkg::*; #(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fsf_item_if.sink             item,
	fsf_result_if.source         result,
	input  logic                 cfg_we,
	input  logic [TAPS_BITS-1:0] cfg_wdata
);

	// Address width of both memories, and width of tap counters that must be
	// able to hold MAX_TAPS itself.
	localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW0  = $clog2(MAX_TAPS + 1);
	localparam int CW   = (CW0 > TAPS_BITS) ? CW0 : TAPS_BITS;
	localparam int PW   = SAMPLE_BITS + COEF_BITS;
	// Sum of up to MAX_TAPS products cannot overflow this width.
	localparam int ACC_W = PW + AW + 1;
	localparam int SH_W  = ACC_W - COEF_FRAC;

	localparam logic [CW-1:0] MAX_C    = CW'(MAX_TAPS);
	localparam logic [CW-1:0] TAPS_RST = CW'((TAPS_RESET > MAX_TAPS) ? MAX_TAPS : TAPS_RESET);
	localparam logic [AW-1:0] LAST_PTR = AW'(MAX_TAPS - 1);

	localparam logic signed [SH_W-1:0] SAT_HI =
		SH_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

	// Engine states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MAC    = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	// Memories. The sample ring holds the newest sample plus MAX_TAPS-1
	// older ones; entries older than the fill count read as zero.
	logic signed [SAMPLE_BITS-1:0] smp_mem  [MAX_TAPS];
	logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];

	logic [1:0]                    state_q;
	logic [CW-1:0]                 taps_q;
	logic [CW-1:0]                 fill_q;
	logic [AW-1:0]                 wp_q;
	logic [AW-1:0]                 rd_ptr_q;
	logic [CW-1:0]                 tap_q;
	logic [MAX_TAPS-1:0]           cvalid_q;

	logic                          v_s1;
	logic                          ok_s1;
	logic                          cv_s1;
	logic signed [SAMPLE_BITS-1:0] smp_rd_s1;
	logic signed [COEF_BITS-1:0]   coef_rd_s1;
	logic                          v_s2;
	logic signed [PW-1:0]          prod_s2;
	logic signed [ACC_W-1:0]       acc_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic                          accept;
	logic                          smp_accept;
	logic                          coef_accept;
	logic                          coef_in_range;
	logic [AW-1:0]                 coef_waddr;
	logic [CW-1:0]                 cfg_ext;
	logic [CW-1:0]                 taps_next;
	logic                          last_tap;
	logic                          out_free;
	logic signed [SAMPLE_BITS-1:0] smp_op;
	logic signed [COEF_BITS-1:0]   coef_op;
	logic signed [SH_W-1:0]        acc_sh;
	logic signed [SAMPLE_BITS-1:0] sat_val;

	// Requests are taken only while the engine is idle, so a write to either
	// memory never meets a read of the same entry.
	assign item.ready    = (state_q == ST_IDLE);
	assign accept        = item.valid && item.ready;
	assign smp_accept    = accept && (item.command == CMD_SAMPLE);
	assign coef_accept   = accept && (item.command == CMD_COEF);
	assign coef_in_range = (32'(item.tap_index) < 32'(MAX_TAPS));
	assign coef_waddr    = AW'(item.tap_index);

	// The tap count saturates at the build size.
	assign cfg_ext   = CW'(cfg_wdata);
	assign taps_next = (cfg_ext > MAX_C) ? MAX_C : cfg_ext;

	assign last_tap = (tap_q == (taps_q - CW'(1)));
	assign out_free = !out_valid_q || result.ready;

	// Memory ports: one write at request time, one registered read per tap.
	always_ff @(posedge clk) begin
		if (smp_accept) begin
			smp_mem[wp_q] <= item.sample;
		end
		if (state_q == ST_MAC) begin
			smp_rd_s1 <= smp_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (coef_accept && coef_in_range) begin
			coef_mem[coef_waddr] <= item.coeff_value;
		end
		if (state_q == ST_MAC) begin
			coef_rd_s1 <= coef_mem[tap_q[AW-1:0]];
		end
	end

	// Unwritten coefficients and samples older than the history read as zero.
	assign smp_op  = ok_s1 ? smp_rd_s1 : '0;
	assign coef_op = cv_s1 ? coef_rd_s1 : '0;

	// Floor shift, then saturate to the sample range.
	assign acc_sh  = SH_W'(acc_q >>> COEF_FRAC);
	assign sat_val = (acc_sh > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
	                 (acc_sh < SAT_LO) ? SAMPLE_BITS'(SAT_LO) :
	                 SAMPLE_BITS'(acc_sh);

	// Sequencer, configuration, fill count and coefficient valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			taps_q   <= TAPS_RST;
			fill_q   <= '0;
			wp_q     <= '0;
			rd_ptr_q <= '0;
			tap_q    <= '0;
			cvalid_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_MAC);
			v_s2 <= v_s1;

			if (cfg_we) begin
				taps_q <= taps_next;
				fill_q <= '0;
			end

			if (coef_accept && coef_in_range) begin
				cvalid_q[coef_waddr] <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (smp_accept) begin
						if (fill_q < MAX_C) begin
							fill_q <= fill_q + CW'(1);
						end
						wp_q     <= (wp_q == LAST_PTR) ? '0 : wp_q + AW'(1);
						rd_ptr_q <= wp_q;
						tap_q    <= '0;
						state_q  <= (taps_q == '0) ? ST_FINISH : ST_MAC;
					end
				end
				ST_MAC: begin
					rd_ptr_q <= (rd_ptr_q == '0) ? LAST_PTR : rd_ptr_q - AW'(1);
					tap_q    <= tap_q + CW'(1);
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-tap flags travel beside the memory read data.
	always_ff @(posedge clk) begin
		ok_s1 <= (tap_q < fill_q);
		cv_s1 <= cvalid_q[tap_q[AW-1:0]];
	end

	// Multiply, then accumulate one stage later.
	always_ff @(posedge clk) begin
		prod_s2 <= PW'(smp_op) * PW'(coef_op);
		if (smp_accept) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_data_q <= sat_val;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.filtered = out_data_q;

endmodule

### rtl/fsf_checker.sv
// ----------------------------------------------------------------------------
// FIR stream filter checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
module fsf_checker import fsf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   item_valid,
	input logic                   item_ready,
	input logic                   item_command,
	input logic                   result_valid,
	input logic                   result_ready,
	input logic [SAMPLE_BITS-1:0] result_filtered
);

	// A stalled result stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_filtered))
		else $error("result changed while stalled");

	// A sample request occupies the engine for at least the next cycle.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_command == CMD_SAMPLE) |=> !item_ready)
		else $error("request taken right after a sample request");

	// A coefficient request never produces a result.
	a_coef_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_command == CMD_COEF) && !result_valid
		|=> !result_valid)
		else $error("result produced by a coefficient request");

endmodule

bind fir_filter_stream_top fsf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fsf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.item_command    (item.command),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_filtered (result.filtered)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// FIR stream filter testbench
// Drives coefficient loads and samples into the streaming FIR filter under
// bursty input and a stalling output. Each filter result is checked against
// a direct-form FIR computed in the testbench, across several tap counts.
// ----------------------------------------------------------------------------
module tb;
	import fsf_pkg::*;

	localparam int HIST_DEPTH     = MAX_TAPS_DEF - 1;
	// Settle time after draining; leaves a wide margin over the longest sample.
	localparam int SETTLE_CYCLES  = 64;
	// Cycles without any handshake before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Length of the one long output hold-off.
	localparam int HOLD_CYCLES    = 700;
	localparam int PHASE_ITEMS    = 140;
	localparam int MAX_REPORTS    = 10;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	typedef struct {
		logic                        command;
		logic [TAP_IDX_BITS-1:0]     tap_index;
		logic signed [COEF_BITS-1:0] coeff_value;
		logic signed [15:0]          sample;
	} fir_request_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TAPS_BITS-1:0] cfg_wdata;

	fsf_item_if   #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) item_ch ();
	fsf_result_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) result_ch ();

	fir_filter_stream_top #(
		.MAX_TAPS    (MAX_TAPS_DEF),
		.SAMPLE_BITS (SAMPLE_BITS_DEF)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// The initial block fills this queue; the driver drains it.
	fir_request_t pending_reqs[$];
	// Filter outputs predicted at request acceptance, oldest first.
	logic signed [15:0] filtered_due[$];

	// Shadow copy of the filter state, kept in step with accepted requests.
	logic signed [COEF_BITS-1:0] coef_shadow [MAX_TAPS_DEF];
	logic signed [15:0]          hist_shadow [HIST_DEPTH];
	int unsigned                 taps_shadow;

	int  fail_count;
	bit  hold_armed;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Filter prediction
	// ------------------------------------------------------------------------

	// Direct-form sum over the taps in use. The newest sample is tap zero and
	// the older ones come from the shadow history. The sum is floor-shifted
	// by the coefficient fraction width and saturated to 16 signed bits.
	function automatic logic signed [15:0] fir_output(input logic signed [15:0] x);
		logic signed [63:0] acc;
		logic signed [63:0] s;
		logic signed [63:0] c;
		logic signed [63:0] y;
		acc = '0;
		for (int j = 0; j < taps_shadow && j < MAX_TAPS_DEF; j++) begin
			if (j == 0)
				s = 64'(x);
			else
				s = 64'(hist_shadow[j-1]);
			c = 64'(coef_shadow[j]);
			acc += s * c;
		end
		y = acc >>> COEF_FRAC;
		if (y > 64'sd32767)
			y = 64'sd32767;
		if (y < -64'sd32768)
			y = -64'sd32768;
		// Zero taps still advance the history.
		for (int j = HIST_DEPTH - 1; j > 0; j--)
			hist_shadow[j] = hist_shadow[j-1];
		hist_shadow[0] = x;
		return y[15:0];
	endfunction

	// Applies one accepted request to the shadow state.
	task automatic track_request(input logic cmd, input logic [TAP_IDX_BITS-1:0] idx,
			input logic signed [COEF_BITS-1:0] cval, input logic signed [15:0] smp);
		if (cmd == CMD_COEF) begin
			// A coefficient load never gives a result or touches the history.
			if (idx < MAX_TAPS_DEF)
				coef_shadow[idx] = cval;
		end else begin
			filtered_due.push_back(fir_output(smp));
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// A Q1.15 value that favors the extremes; the gentle form also favors
	// small magnitudes, so that many sums stay clear of saturation.
	function automatic logic signed [15:0] pick_q15(input bit gentle);
		int unsigned r;
		int          v;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 16'sh8000;
		if (r == 1)
			return 16'sh7fff;
		if (r == 2)
			return 16'sh0000;
		if (gentle && r < 9) begin
			v = $urandom_range(0, 4095);
			return 16'(v - 2048);
		end
		return 16'($urandom);
	endfunction

	task automatic queue_coef(input int unsigned idx, input logic signed [15:0] cval);
		fir_request_t r;
		r.command     = CMD_COEF;
		r.tap_index   = idx[TAP_IDX_BITS-1:0];
		r.coeff_value = cval;
		r.sample      = 16'($urandom);
		pending_reqs.push_back(r);
	endtask

	task automatic queue_sample(input logic signed [15:0] smp);
		fir_request_t r;
		r.command     = CMD_SAMPLE;
		r.tap_index   = TAP_IDX_BITS'($urandom);
		r.coeff_value = 16'($urandom);
		r.sample      = smp;
		pending_reqs.push_back(r);
	endtask

	// Waits until every request is taken and every result is back, then lets
	// the engine settle in case a coefficient load is still in flight.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || item_ch.valid || filtered_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writing the tap count also clears the sample history.
	task automatic write_taps(input int unsigned value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value[TAPS_BITS-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		taps_shadow = (value > MAX_TAPS_DEF) ? MAX_TAPS_DEF : value;
		foreach (hist_shadow[j])
			hist_shadow[j] = '0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned taps_plan[10];
		int unsigned lim;
		taps_plan = '{0, 1, 63, 33, 2, 17, 31, 5, 32, 9};

		// Every block input starts at a known value before reset is released.
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		item_ch.valid         = 1'b0;
		item_ch.command       = CMD_SAMPLE;
		item_ch.tap_index     = '0;
		item_ch.coeff_value   = '0;
		item_ch.sample        = '0;
		result_ch.ready       = 1'b0;
		fail_count            = 0;
		hold_armed            = 1'b0;
		taps_shadow           = TAPS_RESET;
		foreach (coef_shadow[j])
			coef_shadow[j] = '0;
		foreach (hist_shadow[j])
			hist_shadow[j] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, run at the reset tap count of 32.
		// With every coefficient still zero the output is zero.
		queue_sample(16'sd12345);
		// Extreme coefficients at both ends of the store.
		queue_coef(0, 16'sh7fff);
		queue_coef(31, 16'sh8000);
		queue_coef(1, 16'sh8000);
		queue_sample(16'sh7fff);
		queue_sample(16'sh8000);
		queue_sample(16'sh0000);
		queue_sample(16'sh0001);
		queue_sample(16'shffff);
		// Four taps of the most negative coefficient drive the sum past the
		// positive limit with negative samples and past the negative limit
		// with positive ones.
		queue_coef(0, 16'sh8000);
		queue_coef(2, 16'sh8000);
		queue_coef(3, 16'sh8000);
		repeat (4) queue_sample(16'sh8000);
		repeat (4) queue_sample(16'sh7fff);
		// More random samples extend the history, still short of its far end.
		for (int k = 0; k < 3; k++)
			queue_sample(pick_q15(1'b0));
		wait_drained();

		// Random phases, one tap count each, including zero and counts above
		// the build size that must saturate.
		for (int p = 0; p < 10; p++) begin
			write_taps(taps_plan[p]);
			// The long output hold-off falls in a slow, full-length phase.
			if (p == 2)
				hold_armed = 1'b1;
			lim = (taps_shadow == 0) ? 1 : taps_shadow;
			// Load taps that are in use first, so the sums are not trivial.
			for (int k = 0; k < 8; k++)
				queue_coef($urandom_range(0, lim - 1), pick_q15(1'($urandom_range(0, 1))));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 15) begin
					if ($urandom_range(0, 1))
						queue_coef($urandom_range(0, lim - 1), pick_q15(1'b1));
					else
						queue_coef($urandom_range(0, MAX_TAPS_DEF - 1), pick_q15(1'b0));
				end else begin
					queue_sample(pick_q15(1'($urandom_range(0, 1))));
				end
			end
			wait_drained();
		end

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------------
	// Sends in bursts of random length with random gaps. A request that is
	// offered stays on the bus until it is taken. An accepted request updates
	// the shadow state at the edge that takes it.
	int unsigned  burst_left;
	int unsigned  gap_left;
	fir_request_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				track_request(item_ch.command, item_ch.tap_index,
					item_ch.coeff_value, item_ch.sample);
			if (!(item_ch.valid && !item_ch.ready)) begin
				if (gap_left > 0) begin
					item_ch.valid <= 1'b0;
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					next_req = pending_reqs.pop_front();
					item_ch.valid       <= 1'b1;
					item_ch.command     <= next_req.command;
					item_ch.tap_index   <= next_req.tap_index;
					item_ch.coeff_value <= next_req.coeff_value;
					item_ch.sample      <= next_req.sample;
					if (burst_left <= 1) begin
						// Now and then a long burst with no gap at all.
						if ($urandom_range(0, 7) == 0) begin
							burst_left = $urandom_range(60, 200);
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(1, 24);
							gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
						end
					end else begin
						burst_left--;
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver
	// ------------------------------------------------------------------------
	// Switches between stall patterns of random length. Once armed, it holds
	// off for a long stretch while the driver keeps offering, so the output
	// register and the engine fill and the input stalls.
	rx_mode_t    rx_mode;
	int unsigned mode_left;
	int unsigned hold_left;
	int unsigned rx_tick;
	bit          hold_taken;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_mode    = RX_OPEN;
			mode_left  = 0;
			hold_left  = 0;
			rx_tick    = 0;
			hold_taken = 1'b0;
		end else begin
			rx_tick++;
			if (hold_armed && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 200);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_OPEN: begin
						result_ch.ready <= 1'b1;
					end
					RX_COIN: begin
						result_ch.ready <= 1'($urandom_range(0, 1));
					end
					RX_SPARSE: begin
						result_ch.ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						result_ch.ready <= (rx_tick[2:0] != 3'd7);
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------------
	// Each accepted result is matched with the oldest predicted output.
	logic signed [15:0] want_filtered;

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (filtered_due.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("[%0t] unexpected result: filtered=%0d", $realtime,
						result_ch.filtered);
				fail_count++;
			end else begin
				want_filtered = filtered_due.pop_front();
				if (result_ch.filtered !== want_filtered) begin
					if (fail_count < MAX_REPORTS)
						$display("[%0t] filtered mismatch: expected %0d, actual %0d",
							$realtime, want_filtered, result_ch.filtered);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	// Counts cycles in which neither channel completes a handshake.
	int unsigned quiet_cycles;

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] no handshake for %0d cycles", $realtime, quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule
